>>> src/rsor_pkg.sv
// ----------------------------------------------------------------------------
// rsor_pkg
// Shared types and constants of the range scan outlier filter.
// ----------------------------------------------------------------------------
package rsor_pkg;

  // Range codes
  localparam logic [1:0] CODE_FINITE = 2'd0;
  localparam logic [1:0] CODE_INF    = 2'd1;
  localparam logic [1:0] CODE_NAN    = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RANGE_MIN = 2'd1;
  localparam logic [1:0] REG_RANGE_MAX = 2'd2;

  localparam int CFG_W     = 16;
  localparam int CODE_W    = 2;
  localparam int INT_W     = 16;
  localparam int ADDR_W    = 4;
  localparam int APB_W     = 32;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd100;
  localparam logic [CFG_W-1:0] RANGE_MIN_RST = 16'd0;
  localparam logic [CFG_W-1:0] RANGE_MAX_RST = 16'hFFFF;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic [CFG_W-1:0] threshold;
    logic [CFG_W-1:0] min_mm;
    logic [CFG_W-1:0] max_mm;
  } cfg_t;

  // Which of the two result slots the front fills this cycle
  typedef struct packed {
    logic held;   // held point leaves the window
    logic tail;   // final point of the scan passes straight through
  } push_t;

endpackage

>>> src/range_scan_outlier_removal.sv
// ----------------------------------------------------------------------------
// range_scan_outlier_removal
// Streaming isolated-point outlier filter for one lidar scan.
// ----------------------------------------------------------------------------
// One point is accepted per clock cycle while the input is not stalled;
// each point is held in a one-point window and leaves when the next point
// is accepted, and the final point of a scan leaves right after the held
// one, so a scan's last beat yields two results (one for a single-point
// scan). Results go through a four-entry queue; the input stalls while
// fewer than two queue slots are free, so sustained input is one point per
// cycle whenever the output is not stalled. The window decision (bounds
// check and two neighbour compares) is combinational, ahead of the queue.
module range_scan_outlier_removal #(
  parameter int RANGE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsor_pkg::ADDR_W-1:0]         paddr,
  input  logic [rsor_pkg::APB_W-1:0]          pwdata,
  output logic [rsor_pkg::APB_W-1:0]          prdata,
  output logic                                pready,
  // Input points
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [RANGE_BITS-1:0]               range_mm,
  input  logic [rsor_pkg::CODE_W-1:0]         range_code,
  input  logic [rsor_pkg::INT_W-1:0]          intensity,
  input  logic                                last,
  // Filtered points
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [RANGE_BITS-1:0]               out_range_mm,
  output logic [rsor_pkg::CODE_W-1:0]         out_range_code,
  output logic [rsor_pkg::INT_W-1:0]          out_intensity,
  output logic                                out_last
);

  localparam int EW = RANGE_BITS + rsor_pkg::CODE_W + rsor_pkg::INT_W + 1;

  rsor_pkg::cfg_t                 cfg;
  rsor_pkg::push_t                push;
  logic [EW-1:0]                  ent_held;
  logic [EW-1:0]                  ent_tail;
  logic [EW-1:0]                  out_data;
  logic                           room;
  logic                           accept;
  logic [rsor_pkg::QCNT_W-1:0]    q_count;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  rsor_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsor_front #(.RANGE_BITS(RANGE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .range_mm   (range_mm),
    .range_code (range_code),
    .intensity  (intensity),
    .last       (last),
    .push       (push),
    .ent_held   (ent_held),
    .ent_tail   (ent_tail)
  );

  rsor_queue #(.DATA_W(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ent_held  (ent_held),
    .ent_tail  (ent_tail),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  assign out_range_mm   = out_data[EW-1 -: RANGE_BITS];
  assign out_range_code = out_data[rsor_pkg::INT_W+1 +: rsor_pkg::CODE_W];
  assign out_intensity  = out_data[1 +: rsor_pkg::INT_W];
  assign out_last       = out_data[0];

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= rsor_pkg::QCNT_W'(rsor_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // Final point of a scan is always queued for output the next cycle
  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) |=> out_valid)
    else $error("final point not queued");

  // A non-finite result never carries a range
  a_nonfinite_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_range_code != rsor_pkg::CODE_FINITE) |-> (out_range_mm == '0))
    else $error("non-finite result with nonzero range");

endmodule

>>> src/rsor_cfg.sv
// ----------------------------------------------------------------------------
// rsor_cfg
// APB register file: threshold and validity bounds.
// ----------------------------------------------------------------------------
module rsor_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsor_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsor_pkg::APB_W-1:0]    pwdata,
  output logic [rsor_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  output rsor_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= rsor_pkg::THRESHOLD_RST;
      cfg.min_mm    <= rsor_pkg::RANGE_MIN_RST;
      cfg.max_mm    <= rsor_pkg::RANGE_MAX_RST;
    end else if (wr_en) begin
      case (idx)
        rsor_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[rsor_pkg::CFG_W-1:0];
        rsor_pkg::REG_RANGE_MIN: cfg.min_mm    <= pwdata[rsor_pkg::CFG_W-1:0];
        rsor_pkg::REG_RANGE_MAX: cfg.max_mm    <= pwdata[rsor_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      rsor_pkg::REG_THRESHOLD: prdata[rsor_pkg::CFG_W-1:0] = cfg.threshold;
      rsor_pkg::REG_RANGE_MIN: prdata[rsor_pkg::CFG_W-1:0] = cfg.min_mm;
      rsor_pkg::REG_RANGE_MAX: prdata[rsor_pkg::CFG_W-1:0] = cfg.max_mm;
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> src/rsor_front.sv
// ----------------------------------------------------------------------------
// rsor_front
// One-point window: classifies the held point against both neighbours and
// hands up to two finished results to the queue per accepted beat.
// ----------------------------------------------------------------------------
module rsor_front #(
  parameter int RANGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rsor_pkg::cfg_t                 cfg,
  input  logic                           accept,
  input  logic [RANGE_BITS-1:0]          range_mm,
  input  logic [rsor_pkg::CODE_W-1:0]    range_code,
  input  logic [rsor_pkg::INT_W-1:0]     intensity,
  input  logic                           last,
  output rsor_pkg::push_t                push,
  output logic [RANGE_BITS+rsor_pkg::CODE_W+rsor_pkg::INT_W:0] ent_held,
  output logic [RANGE_BITS+rsor_pkg::CODE_W+rsor_pkg::INT_W:0] ent_tail
);

  localparam int CW = (RANGE_BITS > rsor_pkg::CFG_W) ? RANGE_BITS : rsor_pkg::CFG_W;

  // Window state
  logic [RANGE_BITS-1:0]       held_range;
  logic [1:0]                  held_code;
  logic [rsor_pkg::INT_W-1:0]  held_intensity;
  logic [RANGE_BITS-1:0]       emitted_range;
  logic [1:0]                  emitted_code;
  logic [1:0]                  window_fill;

  logic [RANGE_BITS-1:0]       in_r;
  logic [1:0]                  in_c;
  logic                        in_bounds;
  logic                        remove;
  logic [RANGE_BITS-1:0]       o_range;
  logic [1:0]                  o_code;
  logic [rsor_pkg::INT_W-1:0]  o_int;

  // Finite neighbour exceeds when |cur - n| > threshold; inf always, NaN never
  function automatic logic exceeds(input logic [RANGE_BITS-1:0] cur,
                                   input logic [RANGE_BITS-1:0] nr,
                                   input logic [1:0]            nc,
                                   input logic [rsor_pkg::CFG_W-1:0] thr);
    logic [RANGE_BITS-1:0] diff;
    logic                  res;
    diff = (cur >= nr) ? (cur - nr) : (nr - cur);
    if (nc == rsor_pkg::CODE_INF)
      res = 1'b1;
    else if (nc != rsor_pkg::CODE_FINITE)
      res = 1'b0;
    else
      res = CW'(diff) > CW'(thr);
    return res;
  endfunction

  // Normalize the incoming point
  always_comb begin
    in_c = (range_code > rsor_pkg::CODE_NAN) ? rsor_pkg::CODE_NAN : range_code;
    in_r = (in_c == rsor_pkg::CODE_FINITE) ? range_mm : '0;
  end

  // Outlier decision on the held point
  assign in_bounds = (CW'(held_range) >= CW'(cfg.min_mm)) &&
                     (CW'(held_range) <= CW'(cfg.max_mm));

  assign remove = (window_fill == 2'd2) && (held_code == rsor_pkg::CODE_FINITE) &&
                  in_bounds &&
                  exceeds(held_range, emitted_range, emitted_code, cfg.threshold) &&
                  exceeds(held_range, in_r, in_c, cfg.threshold);

  always_comb begin
    o_range = remove ? '0 : held_range;
    o_code  = remove ? rsor_pkg::CODE_INF : held_code;
    o_int   = remove ? '0 : held_intensity;
  end

  assign push.held = accept && (window_fill != 2'd0);
  assign push.tail = accept && last;
  assign ent_held  = {o_range, o_code, o_int, 1'b0};
  assign ent_tail  = {in_r, in_c, intensity, 1'b1};

  // Window fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= 2'd0;
    end else if (accept) begin
      if (last)
        window_fill <= 2'd0;
      else
        window_fill <= (window_fill == 2'd0) ? 2'd1 : 2'd2;
    end
  end

  // Held and emitted points
  always_ff @(posedge clk) begin
    if (accept) begin
      if (last) begin
        emitted_range <= in_r;
        emitted_code  <= in_c;
      end else begin
        held_range     <= in_r;
        held_code      <= in_c;
        held_intensity <= intensity;
        if (window_fill != 2'd0) begin
          emitted_range <= o_range;
          emitted_code  <= o_code;
        end
      end
    end
  end

endmodule

>>> src/rsor_queue.sv
// ----------------------------------------------------------------------------
// rsor_queue
// Small result queue: takes up to two entries per cycle, drains one per beat.
// ----------------------------------------------------------------------------
module rsor_queue #(
  parameter int DATA_W = 35
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsor_pkg::push_t               push,
  input  logic [DATA_W-1:0]             ent_held,
  input  logic [DATA_W-1:0]             ent_tail,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [DATA_W-1:0]             out_data,
  output logic [rsor_pkg::QCNT_W-1:0]   count
);

  logic [DATA_W-1:0]              mem [rsor_pkg::QUEUE_DEPTH];
  logic [rsor_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rsor_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rsor_pkg::QPTR_W-1:0]    wr_ptr1;
  logic [DATA_W-1:0]              d0;
  logic                           pop;
  logic [rsor_pkg::QCNT_W-1:0]    n_in;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // Room for a worst-case beat of two results
  assign room      = (count <= rsor_pkg::QCNT_W'(rsor_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + rsor_pkg::QPTR_W'(1);
  assign d0        = push.held ? ent_held : ent_tail;
  assign n_in      = rsor_pkg::QCNT_W'(push.held) + rsor_pkg::QCNT_W'(push.tail);

  // Storage
  always_ff @(posedge clk) begin
    if (push.held || push.tail)
      mem[wr_ptr] <= d0;
    if (push.held && push.tail)
      mem[wr_ptr1] <= ent_tail;
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rsor_pkg::QPTR_W'(n_in);
      if (pop)
        rd_ptr <= rd_ptr + rsor_pkg::QPTR_W'(1);
      count <= count + n_in - rsor_pkg::QCNT_W'(pop);
    end
  end

endmodule
